>>> design/gba_pkg.sv
// Shared types, constants and the exponential table for the Gaussian
// broadening accumulator. No dependencies; used by every module of the block.
package gba_pkg;

  localparam int NUM_PAIRS         = 16;
  localparam int GRID_POINTS       = 1024;
  localparam int EXP_TABLE_ENTRIES = 1024;

  localparam int ADDR_W    = $clog2(GRID_POINTS);
  localparam int COUNT_W   = $clog2(GRID_POINTS + 1);
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES);
  localparam int EXP_W     = 31;
  localparam int ACC_W     = 48;
  localparam int TERM_W    = 51;
  localparam int SUM_W     = TERM_W + 2;

  // Cycles from the last issued token until it has left the last cell.
  localparam int DRAIN_CYCLES = 8 + 2 * NUM_PAIRS + 2;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

  localparam logic [1:0] OP_WRITE_GRID = 2'd0;
  localparam logic [1:0] OP_ACCUM      = 2'd1;
  localparam logic [1:0] OP_READ       = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  localparam logic [1:0] CFG_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_SCALE  = 2'd1;
  localparam logic [1:0] CFG_PEAK   = 2'd2;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(64'sh0000_7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-64'sh0000_8000_0000_0000);

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         pair_index;
    logic [9:0]         grid_index;
    logic signed [31:0] grid_energy;
    logic signed [31:0] band_energy;
    logic [31:0]        k_point_weight;
    logic signed [31:0] band_weight;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] bin_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic [3:0]        pair;
    logic [ADDR_W-1:0] addr;
  } issue_t;

  typedef struct packed {
    logic signed [31:0] eps;
    logic [63:0]        cp;
    logic               neg;
  } ctx_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic [3:0]        pair;
    logic [ADDR_W-1:0] addr;
    logic              neg;
    logic [TERM_W-1:0] term;
    logic [ACC_W-1:0]  rdata;
    logic              rsat;
  } tok_t;

  typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_ENTRIES];

  // Long division by shift and subtract, used while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-i/EXP_TABLE_ENTRIES) by a Taylor series in Q.48, then raised to the
  // sixteenth power by four rounded squarings in Q1.31, ending in Q1.30.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      term = 64'd1 << 48;
      sum  = term;
      for (int k = 1; k <= 24; k++) begin
        term = udiv64(term * 64'(i), 64'(EXP_TABLE_ENTRIES) * 64'(k));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
      v = (sum + (64'd1 << 16)) >> 17;
      for (int s = 0; s < 4; s++) begin
        v = (v * v + (64'd1 << 30)) >> 31;
      end
      rom[i] = EXP_W'((v + 64'd1) >> 1);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> design/gba_term_pipe.sv
// Per-bin term pipeline: grid table, distance, exponent argument, table
// lookup and scaling by the item coefficient. Depends on gba_pkg.
module gba_term_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         grid_write,
  input  logic [gba_pkg::ADDR_W-1:0]   grid_addr,
  input  logic signed [31:0]           grid_data,
  input  logic [31:0]                  exponent_scale,
  input  gba_pkg::ctx_t                ctx,
  input  gba_pkg::issue_t              issue,
  output gba_pkg::tok_t                tok_out
);

  logic signed [31:0] grid_mem [gba_pkg::GRID_POINTS];
  logic [gba_pkg::EXP_W-1:0] exp_rom [gba_pkg::EXP_TABLE_ENTRIES];
  assign exp_rom = gba_pkg::EXP_ROM;

  gba_pkg::issue_t tok0, tok1, tok2, tok3, tok4, tok5, tok6;
  logic signed [31:0] grid_q;
  logic [31:0] m1;
  logic [63:0] d2;
  logic [63:0] ph, pl;
  logic zero4, zero5;
  logic [gba_pkg::EXP_IDX_W-1:0] idx4;
  logic [gba_pkg::EXP_W-1:0] g5;
  logic [62:0] a6, b6;

  logic signed [32:0] diff;
  logic [63:0] x;
  logic [20+gba_pkg::EXP_IDX_W:0] idx_prod;
  logic [gba_pkg::EXP_W-1:0] gz;
  logic [63:0] lo;

  assign diff = 33'(grid_q) - 33'(ctx.eps);
  assign x = ph + (pl >> 32);
  assign idx_prod = (20 + gba_pkg::EXP_IDX_W + 1)'(x[19:0])
                  * (20 + gba_pkg::EXP_IDX_W + 1)'(gba_pkg::EXP_TABLE_ENTRIES);
  assign gz = zero5 ? '0 : g5;
  assign lo = {20'd0, a6[11:0], 32'd0} + {1'b0, b6} + (64'd1 << 43);

  always_ff @(posedge clk) begin
    if (grid_write) begin
      grid_mem[grid_addr] <= grid_data;
    end
    grid_q <= grid_mem[issue.addr];
    m1     <= diff[32] ? 32'(-diff) : diff[31:0];
    d2     <= 64'(m1) * 64'(m1);
    ph     <= 64'(exponent_scale) * 64'(d2[63:32]);
    pl     <= 64'(exponent_scale) * 64'(d2[31:0]);
    zero4  <= x >= (64'd1 << 20);
    idx4   <= idx_prod[20 +: gba_pkg::EXP_IDX_W];
    g5     <= exp_rom[idx4];
    zero5  <= zero4;
    a6     <= 63'(ctx.cp[63:32]) * 63'(gz);
    b6     <= 63'(ctx.cp[31:0]) * 63'(gz);
    tok0 <= issue;
    tok1 <= tok0;
    tok2 <= tok1;
    tok3 <= tok2;
    tok4 <= tok3;
    tok5 <= tok4;
    tok6 <= tok5;
    tok_out.op    <= tok6.op;
    tok_out.pair  <= tok6.pair;
    tok_out.addr  <= tok6.addr;
    tok_out.neg   <= ctx.neg;
    tok_out.term  <= gba_pkg::TERM_W'(a6 >> 12) + gba_pkg::TERM_W'(lo >> 44);
    tok_out.rdata <= '0;
    tok_out.rsat  <= 1'b0;
    tok_out.valid <= tok6.valid;
    if (rst) begin
      tok0.valid    <= 1'b0;
      tok1.valid    <= 1'b0;
      tok2.valid    <= 1'b0;
      tok3.valid    <= 1'b0;
      tok4.valid    <= 1'b0;
      tok5.valid    <= 1'b0;
      tok6.valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end
  end

endmodule

>>> design/gba_cell.sv
// One cell of the accumulator chain: holds the row of one bond pair and
// passes each token on through two registers, tok_a and tok_out. Depends on gba_pkg.
module gba_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    cell_id,
  input  gba_pkg::tok_t tok_in,
  output gba_pkg::tok_t tok_out
);

  logic [gba_pkg::ACC_W:0] row_mem [gba_pkg::GRID_POINTS];
  logic [gba_pkg::ACC_W:0] rd;
  gba_pkg::tok_t tok_a;

  logic hit;
  logic signed [gba_pkg::SUM_W-1:0] old_s, term_s, sum, clamped;
  logic sat;
  logic [gba_pkg::ACC_W:0] wdata;

  assign hit    = tok_a.valid && (tok_a.pair == cell_id);
  assign old_s  = gba_pkg::SUM_W'(signed'(rd[gba_pkg::ACC_W-1:0]));
  assign term_s = gba_pkg::SUM_W'(tok_a.term);
  assign sum    = tok_a.neg ? old_s - term_s : old_s + term_s;

  always_comb begin
    sat     = 1'b0;
    clamped = sum;
    if (sum > gba_pkg::ACC_MAX) begin
      sat     = 1'b1;
      clamped = gba_pkg::ACC_MAX;
    end else if (sum < gba_pkg::ACC_MIN) begin
      sat     = 1'b1;
      clamped = gba_pkg::ACC_MIN;
    end
    if (tok_a.op == gba_pkg::OP_CLEAR) begin
      wdata = '0;
    end else begin
      wdata = {rd[gba_pkg::ACC_W] | sat, clamped[gba_pkg::ACC_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    rd    <= row_mem[tok_in.addr];
    tok_a <= tok_in;
    if (tok_a.valid && (tok_a.op == gba_pkg::OP_CLEAR
        || (tok_a.op == gba_pkg::OP_ACCUM && hit))) begin
      row_mem[tok_a.addr] <= wdata;
    end
    tok_out <= tok_a;
    if (hit && tok_a.op == gba_pkg::OP_READ) begin
      tok_out.rdata <= rd[gba_pkg::ACC_W-1:0];
      tok_out.rsat  <= rd[gba_pkg::ACC_W];
    end
    if (rst) begin
      tok_a.valid   <= 1'b0;
      tok_out.valid <= 1'b0;
    end
  end

endmodule

>>> design/gaussian_broadening_accumulator_unit.sv
// Top level of the Gaussian broadening accumulator: controller, coefficient
// path, term pipeline and the chain of per-pair cells. Depends on gba_pkg.
//
// The block works on one item at a time. A grid write is taken while the
// block stays idle. An accumulate item forms the coefficient in ST_COEF and
// ST_SCALE, sends its n active bins into the term pipeline, one bin per
// cycle, and then waits until the last bin has passed the eight pipeline
// stages and the two-register stage of each of the sixteen cells. An item
// whose coefficient rounds to zero returns to idle after ST_SCALE and sends
// no bin. A read of a bin inside the active count sends one token down the
// same path; its result is registered in the output register as the token
// leaves the last cell. A clear sweeps all GRID_POINTS bins, one per cycle,
// through every cell's row at once. After reset the same clearing pass runs
// first, and no item is accepted until it is done; configuration writes are
// taken at any time. A finished read item waits in the output register
// while further non-read items are accepted.
module gaussian_broadening_accumulator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gba_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_COEF   = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_STREAM = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;

  // Configuration registers.
  logic [10:0] active_grid_points;
  logic [31:0] exponent_scale;
  logic [31:0] peak_height;

  logic [2:0] state;
  logic [gba_pkg::COUNT_W-1:0] cnt;
  logic [gba_pkg::DRAIN_W-1:0] drain_cnt;
  logic [gba_pkg::COUNT_W-1:0] n_active;

  // Item registers of the accumulate item in flight.
  logic [3:0]  item_pair;
  logic [31:0] item_kw;
  logic [31:0] item_bmag;
  logic [31:0] cmag;
  gba_pkg::ctx_t ctx;

  gba_pkg::issue_t issue;
  gba_pkg::tok_t   chain [gba_pkg::NUM_PAIRS + 1];

  logic accept;
  logic pair_ok;
  logic [31:0] kw_clamp;
  logic [31:0] bmag;
  logic [63:0] coef_prod;

  // Values of the configured count above the grid size act as the grid size.
  assign n_active = (active_grid_points > 11'(gba_pkg::GRID_POINTS))
                  ? gba_pkg::COUNT_W'(gba_pkg::GRID_POINTS)
                  : gba_pkg::COUNT_W'(active_grid_points);

  // A read is held off while an earlier result still waits, so the result
  // register is always free when a read token leaves the chain.
  assign in_ready = (state == ST_IDLE) && !(out_valid && in_data.opcode == gba_pkg::OP_READ);
  assign accept   = in_valid && in_ready;
  assign pair_ok  = int'(in_data.pair_index) < gba_pkg::NUM_PAIRS;

  // K weights above one are taken as one; the band weight goes by magnitude.
  assign kw_clamp  = (in_data.k_point_weight > 32'h8000_0000) ? 32'h8000_0000
                                                              : in_data.k_point_weight;
  assign bmag      = in_data.band_weight[31] ? 32'(-in_data.band_weight)
                                             : in_data.band_weight;
  assign coef_prod = 64'(item_kw) * 64'(item_bmag) + (64'd1 << 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_grid_points <= 11'd1024;
      exponent_scale     <= 32'd32768;
      peak_height        <= 32'd26145;
    end else if (cfg_write) begin
      case (cfg_index)
        gba_pkg::CFG_ACTIVE: active_grid_points <= cfg_data[10:0];
        gba_pkg::CFG_SCALE:  exponent_scale     <= cfg_data;
        gba_pkg::CFG_PEAK:   peak_height        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    issue.valid <= 1'b0;
    if (rst) begin
      state     <= ST_SWEEP;
      cnt       <= '0;
      drain_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.opcode)
              gba_pkg::OP_ACCUM: begin
                if (pair_ok) state <= ST_COEF;
              end
              gba_pkg::OP_READ: begin
                if (pair_ok && 11'(in_data.grid_index) < 11'(n_active)) begin
                  issue.valid <= 1'b1;
                  issue.op    <= gba_pkg::OP_READ;
                  issue.pair  <= in_data.pair_index;
                  issue.addr  <= gba_pkg::ADDR_W'(in_data.grid_index);
                  drain_cnt   <= gba_pkg::DRAIN_W'(gba_pkg::DRAIN_CYCLES);
                  state       <= ST_DRAIN;
                end
              end
              gba_pkg::OP_CLEAR: begin
                cnt   <= '0;
                state <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          issue.valid <= 1'b1;
          issue.op    <= gba_pkg::OP_CLEAR;
          issue.addr  <= cnt[gba_pkg::ADDR_W-1:0];
          cnt         <= cnt + 1'b1;
          if (cnt == gba_pkg::COUNT_W'(gba_pkg::GRID_POINTS - 1)) begin
            drain_cnt <= gba_pkg::DRAIN_W'(gba_pkg::DRAIN_CYCLES);
            state     <= ST_DRAIN;
          end
        end
        ST_COEF: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          // A coefficient that rounds to zero leaves every bin unchanged.
          cnt <= '0;
          if (cmag == 32'd0) begin
            state <= ST_IDLE;
          end else if (n_active == '0) begin
            drain_cnt <= gba_pkg::DRAIN_W'(gba_pkg::DRAIN_CYCLES);
            state     <= ST_DRAIN;
          end else begin
            state <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          issue.valid <= 1'b1;
          issue.op    <= gba_pkg::OP_ACCUM;
          issue.pair  <= item_pair;
          issue.addr  <= cnt[gba_pkg::ADDR_W-1:0];
          cnt         <= cnt + 1'b1;
          if (cnt == n_active - 1'b1) begin
            drain_cnt <= gba_pkg::DRAIN_W'(gba_pkg::DRAIN_CYCLES);
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt - 1'b1;
          if (drain_cnt == '0) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Coefficient path: latch the operands, round the weight product to Q2.30,
  // then scale it by the peak height for the whole sweep.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_pair <= in_data.pair_index;
      item_kw   <= kw_clamp;
      item_bmag <= bmag;
      ctx.eps   <= in_data.band_energy;
      ctx.neg   <= in_data.band_weight[31];
    end
    if (state == ST_COEF) begin
      cmag <= coef_prod[62:31];
    end
    if (state == ST_SCALE) begin
      ctx.cp <= 64'(cmag) * 64'(peak_height);
    end
  end

  gba_term_pipe u_term_pipe (
    .clk            (clk),
    .rst            (rst),
    .grid_write     (accept && in_data.opcode == gba_pkg::OP_WRITE_GRID
                     && 11'(in_data.grid_index) < 11'(gba_pkg::GRID_POINTS)),
    .grid_addr      (gba_pkg::ADDR_W'(in_data.grid_index)),
    .grid_data      (in_data.grid_energy),
    .exponent_scale (exponent_scale),
    .ctx            (ctx),
    .issue          (issue),
    .tok_out        (chain[0])
  );

  for (genvar k = 0; k < gba_pkg::NUM_PAIRS; k++) begin : g_cell
    gba_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (4'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // Result register: a read token leaving the last cell carries the bin.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain[gba_pkg::NUM_PAIRS].valid
                 && chain[gba_pkg::NUM_PAIRS].op == gba_pkg::OP_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (chain[gba_pkg::NUM_PAIRS].valid && chain[gba_pkg::NUM_PAIRS].op == gba_pkg::OP_READ) begin
      out_data.bin_value <= chain[gba_pkg::NUM_PAIRS].rdata;
      out_data.saturated <= chain[gba_pkg::NUM_PAIRS].rsat;
    end
  end

`ifndef NO_ASSERTIONS
  // A read result must never find the result register still occupied.
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (chain[gba_pkg::NUM_PAIRS].valid && chain[gba_pkg::NUM_PAIRS].op == gba_pkg::OP_READ)
    |-> !out_valid)
    else $error("read result arrived while output register was full");

  // The clearing pass after reset keeps items out.
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("item accepted during clearing pass");

  // The bin counter stays inside the active range while streaming.
  a_stream_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> (cnt < n_active))
    else $error("stream counter beyond active grid count");
`endif

endmodule

>>> sim/gaussian_broadening_accumulator_unit_tb.sv
// Self-checking testbench for the Gaussian broadening accumulator unit.
// Depends on gba_pkg and gaussian_broadening_accumulator_unit from the design folder.
module gaussian_broadening_accumulator_unit_tb;

  // Predicts the block: grid table, accumulator rows, sticky marks and the
  // three registers, plus the queue of bin reads still to arrive.
  class bin_scoreboard;
    logic signed [47:0] acc_row [gba_pkg::NUM_PAIRS*gba_pkg::GRID_POINTS];
    bit                 sat_mark [gba_pkg::NUM_PAIRS*gba_pkg::GRID_POINTS];
    logic signed [31:0] grid_e [gba_pkg::GRID_POINTS];
    bit [63:0]          gauss_rom [gba_pkg::EXP_TABLE_ENTRIES];
    bit [10:0]          active_reg;
    bit [31:0]          scale_reg;
    bit [31:0]          peak_reg;
    gba_pkg::out_item_t pending_reads [$];
    int                 errors;
    int                 reads_checked;
    int                 sat_seen;

    function new();
      bit [63:0] term, sum, v;
      for (int i = 0; i < gba_pkg::EXP_TABLE_ENTRIES; i++) begin
        term = 64'd1 << 48;
        sum  = term;
        for (int k = 1; k <= 24; k++) begin
          term = term * 64'(i) / (64'(gba_pkg::EXP_TABLE_ENTRIES) * 64'(k));
          if (k % 2) sum -= term;
          else sum += term;
        end
        v = (sum + (64'd1 << 16)) >> 17;
        repeat (4) v = (v * v + (64'd1 << 30)) >> 31;
        gauss_rom[i] = (v + 64'd1) >> 1;
      end
      foreach (grid_e[i]) grid_e[i] = '0;
      clear_rows();
      active_reg = 11'd1024;
      scale_reg  = 32'd32768;
      peak_reg   = 32'd26145;
    endfunction

    function void clear_rows();
      foreach (acc_row[i]) begin
        acc_row[i]  = '0;
        sat_mark[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] val);
      case (idx)
        gba_pkg::CFG_ACTIVE: active_reg = val[10:0];
        gba_pkg::CFG_SCALE:  scale_reg  = val;
        gba_pkg::CFG_PEAK:   peak_reg   = val;
        default: ;
      endcase
    endfunction

    function int active_bins();
      return (int'(active_reg) > gba_pkg::GRID_POINTS) ? gba_pkg::GRID_POINTS
                                                       : int'(active_reg);
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction

    // Table value of exp(-scale * (grid - eps)^2), zero from argument 16 on.
    function bit [63:0] gauss_weight(logic signed [31:0] grid, logic signed [31:0] eps);
      longint     d;
      bit [127:0] m, x;
      d = longint'(grid) - longint'(eps);
      m = (d < 0) ? 128'(-d) : 128'(d);
      x = (128'(scale_reg) * (m * m)) >> 32;
      if (x >= (128'd16 << 16)) return 64'd0;
      return gauss_rom[x >> 10];
    endfunction

    function void accumulate(gba_pkg::in_item_t it);
      bit [63:0]           kw, bmag, cmag, cp, t;
      bit [127:0]          prod;
      bit                  neg;
      longint              bw;
      logic signed [65:0]  s;
      int                  slot;
      kw = 64'(it.k_point_weight);
      if (kw > 64'h8000_0000) kw = 64'h8000_0000;
      bw   = longint'(it.band_weight);
      neg  = bw < 0;
      bmag = neg ? 64'(-bw) : 64'(bw);
      cmag = (kw * bmag + (64'd1 << 30)) >> 31;
      if (cmag == 0) return;
      cp = cmag * 64'(peak_reg);
      for (int e = 0; e < active_bins(); e++) begin
        prod = 128'(cp) * 128'(gauss_weight(grid_e[e], it.band_energy));
        t    = 64'((prod + (128'd1 << 43)) >> 44);
        if (t == 0) continue;
        slot = int'(it.pair_index) * gba_pkg::GRID_POINTS + e;
        s    = neg ? 66'(acc_row[slot]) - $signed({2'b00, t}) :
                     66'(acc_row[slot]) + $signed({2'b00, t});
        if (s > 66'sh0_7FFF_FFFF_FFFF) begin
          s = 66'sh0_7FFF_FFFF_FFFF;
          sat_mark[slot] = 1'b1;
        end else if (s < -66'sh0_8000_0000_0000) begin
          s = -66'sh0_8000_0000_0000;
          sat_mark[slot] = 1'b1;
        end
        acc_row[slot] = s[47:0];
      end
    endfunction

    // Called for every accepted input item.
    function void note_input(gba_pkg::in_item_t it);
      gba_pkg::out_item_t r;
      int                 slot;
      case (it.opcode)
        gba_pkg::OP_WRITE_GRID: grid_e[it.grid_index] = it.grid_energy;
        gba_pkg::OP_CLEAR:      clear_rows();
        gba_pkg::OP_ACCUM:      accumulate(it);
        gba_pkg::OP_READ: begin
          if (int'(it.grid_index) < active_bins()) begin
            slot = int'(it.pair_index) * gba_pkg::GRID_POINTS + int'(it.grid_index);
            r.bin_value = acc_row[slot];
            r.saturated = sat_mark[slot];
            pending_reads.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    // Called for every accepted result item.
    function void check_result(gba_pkg::out_item_t got);
      gba_pkg::out_item_t want;
      if (pending_reads.size() == 0) begin
        $error("unexpected result: bin_value %0d saturated %0d", got.bin_value, got.saturated);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got.saturated) sat_seen++;
      if (got.bin_value !== want.bin_value) begin
        $error("bin_value expected %0d actual %0d", want.bin_value, got.bin_value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated expected %0d actual %0d", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  // Longest time the block may keep working on an item that gives no result.
  localparam int SETTLE_CYCLES = gba_pkg::GRID_POINTS + 150;

  // Grid points loaded at the start; accumulates only run over this many bins.
  localparam int GRID_LOAD = 128;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  gba_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  gba_pkg::out_item_t out_data;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  bin_scoreboard sb;
  int  items_sent;
  bit  long_hold_req;

  gaussian_broadening_accumulator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Result side: sampled at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Receiver stall pattern, changed on the falling edge. A requested long
  // hold keeps ready low so that the block backs up.
  initial begin
    rx_mode_t mode;
    int       left;
    out_ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(2, 0));
        left = int'($urandom_range(200, 10));
      end
      left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= 1'($urandom_range(1, 0));
        default:   out_ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  // Offers one item (called at a falling edge) and returns at the falling
  // edge after it was accepted, leaving valid high for a following item.
  task automatic push_item(gba_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Sender stops until every predicted read has come back.
  task automatic drain_reads();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic write_reg(logic [1:0] idx, bit [31:0] val);
    drain_reads();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_regs(bit [31:0] act, bit [31:0] scale, bit [31:0] peak);
    write_reg(gba_pkg::CFG_ACTIVE, act);
    write_reg(gba_pkg::CFG_SCALE, scale);
    write_reg(gba_pkg::CFG_PEAK, peak);
  endtask

  function automatic gba_pkg::in_item_t make_op(logic [1:0] op, int pair, int gidx,
                                                bit [31:0] eps, bit [31:0] kw, bit [31:0] bw);
    gba_pkg::in_item_t it;
    it.opcode         = op;
    it.pair_index     = 4'(pair);
    it.grid_index     = 10'(gidx);
    it.grid_energy    = $urandom;
    it.band_energy    = eps;
    it.k_point_weight = kw;
    it.band_weight    = bw;
    return it;
  endfunction

  // Random item, weighted toward accumulates near the grid and reads of
  // live bins, with some grid rewrites, clears and wild values. Accumulates
  // only run while the active count stays inside the loaded grid.
  function automatic gba_pkg::in_item_t random_item();
    gba_pkg::in_item_t it;
    int                pick, n, span;
    n    = sb.active_bins();
    span = (n < GRID_LOAD) ? n : GRID_LOAD;
    it.opcode         = 2'($urandom);
    it.pair_index     = 4'($urandom);
    it.grid_index     = 10'($urandom);
    it.grid_energy    = $urandom;
    it.band_energy    = $urandom;
    it.k_point_weight = $urandom;
    it.band_weight    = $urandom;
    pick = int'($urandom_range(99, 0));
    if (pick < 48 && n <= GRID_LOAD) begin
      it.opcode = gba_pkg::OP_ACCUM;
      if ($urandom_range(9, 0) < 8)
        it.band_energy = sb.grid_e[$urandom_range(span - 1, 0)]
                       + $signed($urandom_range(65535, 0)) - 32768;
      if ($urandom_range(3, 0) != 0) it.k_point_weight = $urandom_range(32'h8000_0000, 0);
      if ($urandom_range(3, 0) == 0) it.pair_index = 4'($urandom_range(1, 0));
    end else if (pick < 90) begin
      it.opcode = gba_pkg::OP_READ;
      if ($urandom_range(7, 0) != 0) it.grid_index = 10'($urandom_range(n - 1, 0));
      if ($urandom_range(3, 0) == 0) it.pair_index = 4'($urandom_range(1, 0));
    end else if (pick < 97) begin
      it.opcode = gba_pkg::OP_WRITE_GRID;
      it.grid_energy = $signed($urandom_range(32'h0010_0000, 0)) - 32'sh0008_0000;
    end else begin
      it.opcode = gba_pkg::OP_CLEAR;
    end
    return it;
  endfunction

  initial begin
    bit [31:0] act, scale, peak;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = gba_pkg::CFG_ACTIVE;
    cfg_data  = '0;
    long_hold_req = 1'b0;
    items_sent = 0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load the low part of the grid first so no accumulate ever reads an
    // unwritten point. The two ends carry the most negative and most
    // positive energies.
    for (int i = 0; i < GRID_LOAD; i++) begin
      gba_pkg::in_item_t it;
      it = make_op(gba_pkg::OP_WRITE_GRID, 0, i, 0, 0, 0);
      if (i == 0) it.grid_energy = 32'sh8000_0000;
      else if (i == GRID_LOAD - 1) it.grid_energy = 32'sh7FFF_FFFF;
      else it.grid_energy = (i - GRID_LOAD / 2) * 4096 + $signed($urandom_range(1023, 0));
      push_item(it);
    end

    // Directed part on a short grid.
    set_regs(8, 32'h0001_0000, 26145);
    push_item(make_op(gba_pkg::OP_ACCUM, 0, 0, sb.grid_e[3], 32'h8000_0000, 32'h4000_0000));
    push_item(make_op(gba_pkg::OP_ACCUM, 0, 0, sb.grid_e[5], 32'hFFFF_FFFF, 32'h8000_0000));
    push_item(make_op(gba_pkg::OP_ACCUM, 1, 0, sb.grid_e[2], 32'd1, 32'd1));   // coeff rounds to zero
    push_item(make_op(gba_pkg::OP_ACCUM, 1, 0, sb.grid_e[2], 32'd0, 32'h7FFF_FFFF));
    push_item(make_op(gba_pkg::OP_ACCUM, 15, 0, 32'sh7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    for (int i = 0; i < 8; i++) push_item(make_op(gba_pkg::OP_READ, 0, i, 0, 0, 0));
    push_item(make_op(gba_pkg::OP_READ, 0, 8, 0, 0, 0));     // past the active count
    push_item(make_op(gba_pkg::OP_READ, 15, 1023, 0, 0, 0));
    push_item(make_op(gba_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    push_item(make_op(gba_pkg::OP_READ, 0, 3, 0, 0, 0));

    // Flat Gaussian with the largest peak drives bins into both clamps.
    set_regs(4, 32'd0, 32'hFFFF_FFFF);
    push_item(make_op(gba_pkg::OP_ACCUM, 2, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    push_item(make_op(gba_pkg::OP_ACCUM, 3, 0, 0, 32'h8000_0000, 32'h8000_0000));
    push_item(make_op(gba_pkg::OP_ACCUM, 2, 0, 0, 32'h8000_0000, 32'h8000_0000));
    push_item(make_op(gba_pkg::OP_READ, 2, 0, 0, 0, 0));
    push_item(make_op(gba_pkg::OP_READ, 3, 3, 0, 0, 0));
    push_item(make_op(gba_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    push_item(make_op(gba_pkg::OP_READ, 2, 0, 0, 0, 0));

    // Zero active count: nothing is updated or readable.
    set_regs(0, 32'h0001_0000, 32'h0010_0000);
    push_item(make_op(gba_pkg::OP_ACCUM, 0, 0, sb.grid_e[0], 32'h8000_0000, 32'h4000_0000));
    push_item(make_op(gba_pkg::OP_READ, 0, 0, 0, 0, 0));

    // Random phases over a range of settings, including a count above the
    // grid size where only reads, grid writes and clears are sent.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: act = 1;
        3: act = GRID_LOAD;
        6: act = 2047;               // above the grid size
        default: act = $urandom_range(64, 2);
      endcase
      case ($urandom_range(4, 0))
        0: scale = 0;
        1: scale = 32'hFFFF_FFFF;
        2: scale = $urandom;
        default: scale = $urandom_range(32'h0008_0000, 32'h0000_0100);
      endcase
      case ($urandom_range(4, 0))
        0: peak = 0;
        1: peak = 32'hFFFF_FFFF;
        2: peak = $urandom;
        default: peak = $urandom_range(32'h0004_0000, 1);
      endcase
      set_regs(act, scale, peak);
      for (int j = 0; j < 48; j++) begin
        if (j == 15) long_hold_req = 1'b1;
        if (j == 30) drain_reads();
        else if ($urandom_range(5, 0) == 0) idle_cycles(int'($urandom_range(12, 1)));
        push_item(random_item());
      end
    end

    drain_reads();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d input items and %0d checked bin reads (%0d saturated).",
             items_sent, sb.reads_checked, sb.sat_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(8 * 3_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
